[hw/rtl/dps_pkg.sv]
package dps_pkg;

    localparam int MAX_WIDTH_DEF = 256;
    localparam int HEIGHT_LIMIT  = 4096;

    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;
    localparam int FW_W    = 9;
    localparam int FH_W    = 13;
    localparam int ROW_W   = 12;

    localparam logic [1:0] REG_THR_LOW  = 2'd0;
    localparam logic [1:0] REG_THR_HIGH = 2'd1;
    localparam logic [1:0] REG_WIDTH    = 2'd2;
    localparam logic [1:0] REG_HEIGHT   = 2'd3;

    localparam logic [7:0]      THR_LOW_RST  = 8'd32;
    localparam logic [7:0]      THR_HIGH_RST = 8'd96;
    localparam logic [FW_W-1:0] WIDTH_RST    = 9'd256;
    localparam logic [FH_W-1:0] HEIGHT_RST   = 13'd256;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [1:0] CODE_ZERO = 2'd0;
    localparam logic [1:0] CODE_MID  = 2'd1;
    localparam logic [1:0] CODE_FULL = 2'd2;

    typedef struct packed {
        logic       opcode;
        logic [7:0] pixel_a;
        logic [7:0] pixel_b;
    } t_in_req;

    typedef struct packed {
        logic [7:0] out_pixel;
        logic       last_of_frame;
    } t_out_req;

    function automatic logic [7:0] code_value(input logic [1:0] code);
        logic [7:0] v;
        case (code)
            CODE_ZERO: v = 8'd0;
            CODE_MID:  v = 8'd128;
            default:   v = 8'd255;
        endcase
        return v;
    endfunction

endpackage

[hw/rtl/diff_posterize_sharpen_core.sv]
// A result is registered in stage 1 and then in the output register (or the skid) before
// it shows on o_out_req; the request releasing it is w_used+1 raster positions after the pixel.
// Throughput: one request per cycle while o_in_stall is low, set by the read-modify-write of the line
// buffer memory (read on accept, write back in the following cycle, same-column bypass).
// Reset: synchronous, active low; clears counters, window, handshake and configuration registers.
// The line buffer is not cleared and needs no clearing pass.
module diff_posterize_sharpen_core #(
    parameter int MAX_WIDTH = dps_pkg::MAX_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  dps_pkg::t_in_req                i_in_req,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output dps_pkg::t_out_req               o_out_req,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dps_pkg::ADDR_W-1:0]      paddr,
    input  logic [dps_pkg::DATA_W-1:0]      pwdata,
    output logic [dps_pkg::DATA_W-1:0]      prdata,
    output logic                            pready
);
    import dps_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int XW = ((CW > FW_W) ? CW : FW_W) + 1;

    // configuration
    logic [7:0]      r_thr_low, r_thr_high;
    logic [FW_W-1:0] r_frame_width;
    logic [FH_W-1:0] r_frame_height;
    logic            cfg_wr, geo_wr;
    logic [1:0]      cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[3:2];
    assign geo_wr  = cfg_wr & ((cfg_idx == REG_WIDTH) | (cfg_idx == REG_HEIGHT));

    always_comb begin
        case (cfg_idx)
            REG_THR_LOW:  prdata = {{(DATA_W-8){1'b0}}, r_thr_low};
            REG_THR_HIGH: prdata = {{(DATA_W-8){1'b0}}, r_thr_high};
            REG_WIDTH:    prdata = {{(DATA_W-FW_W){1'b0}}, r_frame_width};
            default:      prdata = {{(DATA_W-FH_W){1'b0}}, r_frame_height};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_low      <= THR_LOW_RST;
            r_thr_high     <= THR_HIGH_RST;
            r_frame_width  <= WIDTH_RST;
            r_frame_height <= HEIGHT_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_THR_LOW:  r_thr_low      <= pwdata[7:0];
                REG_THR_HIGH: r_thr_high     <= pwdata[7:0];
                REG_WIDTH:    r_frame_width  <= pwdata[FW_W-1:0];
                default:      r_frame_height <= pwdata[FH_W-1:0];
            endcase
        end
    end

    // clamped geometry
    logic [XW-1:0]   fw_x, w_used, w_m1, w_p1;
    logic [FH_W-1:0] h_used, h_m1;

    assign fw_x = {{(XW-FW_W){1'b0}}, r_frame_width};

    always_comb begin
        if (fw_x < XW'(3)) begin
            w_used = XW'(3);
        end else if (fw_x > XW'(MAX_WIDTH)) begin
            w_used = XW'(MAX_WIDTH);
        end else begin
            w_used = fw_x;
        end
        if (r_frame_height < FH_W'(3)) begin
            h_used = FH_W'(3);
        end else if (r_frame_height > FH_W'(HEIGHT_LIMIT)) begin
            h_used = FH_W'(HEIGHT_LIMIT);
        end else begin
            h_used = r_frame_height;
        end
    end

    assign w_m1 = w_used - XW'(1);
    assign w_p1 = w_used + XW'(1);
    assign h_m1 = h_used - FH_W'(1);

    // stage 0: position tracking
    logic [ROW_W-1:0] r_in_row, r_out_row, n_in_row, n_out_row;
    logic [CW-1:0]    r_in_col, r_out_col, n_in_col, n_out_col;
    logic [XW-1:0]    r_pend, n_pend;
    logic             in_acc, is_flush, idle, live, emit, out_last, border;
    logic [7:0]       diff;
    logic [1:0]       code;
    logic [XW-1:0]    in_col_x, out_col_x;
    logic [FH_W-1:0]  in_row_x, out_row_x;

    assign in_acc    = i_in_valid & ~o_in_stall;
    assign is_flush  = (i_in_req.opcode == OP_FLUSH);
    assign idle      = (r_in_row == '0) && (r_in_col == '0) &&
                       (r_out_row == '0) && (r_out_col == '0);
    assign live      = in_acc & ~(is_flush & idle);
    assign in_col_x  = {{(XW-CW){1'b0}}, r_in_col};
    assign out_col_x = {{(XW-CW){1'b0}}, r_out_col};
    assign in_row_x  = {1'b0, r_in_row};
    assign out_row_x = {1'b0, r_out_row};

    assign diff = (i_in_req.pixel_a >= i_in_req.pixel_b) ?
                  (i_in_req.pixel_a - i_in_req.pixel_b) :
                  (i_in_req.pixel_b - i_in_req.pixel_a);

    always_comb begin
        if (is_flush) begin
            code = CODE_ZERO;
        end else if (diff < r_thr_low) begin
            code = CODE_ZERO;
        end else if (diff < r_thr_high) begin
            code = CODE_MID;
        end else begin
            code = CODE_FULL;
        end
    end

    assign emit     = (r_pend == w_p1);
    assign out_last = (out_row_x == h_m1) && (out_col_x == w_m1);
    assign border   = (r_out_row == '0) || (out_row_x == h_m1) ||
                      (r_out_col == '0) || (out_col_x == w_m1);

    always_comb begin
        n_in_row  = r_in_row;
        n_in_col  = r_in_col;
        n_out_row = r_out_row;
        n_out_col = r_out_col;
        n_pend    = emit ? r_pend : r_pend + XW'(1);
        if (in_col_x + XW'(1) >= w_used) begin
            n_in_col = '0;
            n_in_row = (in_row_x + FH_W'(1) >= h_used) ? '0 : r_in_row + ROW_W'(1);
        end else begin
            n_in_col = r_in_col + CW'(1);
        end
        if (emit) begin
            if (out_col_x == w_m1) begin
                n_out_col = '0;
                n_out_row = (out_row_x == h_m1) ? '0 : r_out_row + ROW_W'(1);
            end else begin
                n_out_col = r_out_col + CW'(1);
            end
            if (out_last && is_flush) begin
                n_in_row = '0;
                n_in_col = '0;
                n_pend   = '0;
            end
        end
    end

    // stage 1 registers
    logic          r_s1_valid, r_s1_emit, r_s1_border, r_s1_last;
    logic [1:0]    r_s1_code;
    logic [CW-1:0] r_s1_col;
    logic          r_fwd_hit;
    logic [3:0]    r_fwd_data, r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row   <= '0;
            r_in_col   <= '0;
            r_out_row  <= '0;
            r_out_col  <= '0;
            r_pend     <= '0;
            r_s1_valid <= 1'b0;
        end else if (geo_wr) begin
            r_in_row   <= '0;
            r_in_col   <= '0;
            r_out_row  <= '0;
            r_out_col  <= '0;
            r_pend     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= live;
            if (live) begin
                r_in_row  <= n_in_row;
                r_in_col  <= n_in_col;
                r_out_row <= n_out_row;
                r_out_col <= n_out_col;
                r_pend    <= n_pend;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (live) begin
            r_s1_emit   <= emit;
            r_s1_border <= border;
            r_s1_last   <= out_last;
            r_s1_code   <= code;
            r_s1_col    <= r_in_col;
        end
    end

    // line buffer: {two rows above, row above} per column
    logic [3:0] line_mem [MAX_WIDTH];
    logic [3:0] rd_word, wr_word;
    logic [1:0] up_code, mid_code;

    assign rd_word  = r_fwd_hit ? r_fwd_data : r_rd_data;
    assign up_code  = rd_word[3:2];
    assign mid_code = rd_word[1:0];
    assign wr_word  = {mid_code, r_s1_code};

    always_ff @(posedge i_clk) begin
        if (live) begin
            r_rd_data  <= line_mem[r_in_col];
            r_fwd_hit  <= r_s1_valid && (r_s1_col == r_in_col);
            r_fwd_data <= wr_word;
        end
        if (r_s1_valid) begin
            line_mem[r_s1_col] <= wr_word;
        end
    end

    // window: column entering (c2) and the centre row of the column before (c1)
    logic [1:0] r_c2_top, r_c2_mid, r_c2_bot, r_c1_mid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || geo_wr) begin
            r_c2_top <= CODE_ZERO;
            r_c2_mid <= CODE_ZERO;
            r_c2_bot <= CODE_ZERO;
            r_c1_mid <= CODE_ZERO;
        end else if (r_s1_valid) begin
            r_c1_mid <= r_c2_mid;
            r_c2_top <= up_code;
            r_c2_mid <= mid_code;
            r_c2_bot <= r_s1_code;
        end
    end

    // sharpen and clip
    logic [7:0]         v_ctr;
    logic [10:0]        pos_sum;
    logic [9:0]         neg_sum;
    logic signed [11:0] sharp;
    logic [7:0]         clipped, pix;

    assign v_ctr   = code_value(r_c2_mid);
    assign pos_sum = {1'b0, v_ctr, 2'b00} + {3'b000, v_ctr};
    assign neg_sum = {2'b00, code_value(r_c2_top)} + {2'b00, code_value(r_c2_bot)} +
                     {2'b00, code_value(r_c1_mid)} + {2'b00, code_value(mid_code)};
    assign sharp   = $signed({1'b0, pos_sum}) - $signed({2'b00, neg_sum});

    always_comb begin
        if (sharp < 12'sd0) begin
            clipped = 8'd0;
        end else if (sharp > 12'sd255) begin
            clipped = 8'd255;
        end else begin
            clipped = sharp[7:0];
        end
    end

    assign pix = r_s1_border ? v_ctr : clipped;

    // output register with skid
    logic     r_o_valid, r_sk_valid, s1_emit, deq;
    t_out_req r_o_req, r_sk_req, s1_req;

    assign s1_emit = r_s1_valid & r_s1_emit;
    assign deq     = r_o_valid & ~i_out_stall;
    assign s1_req  = '{out_pixel: pix, last_of_frame: r_s1_last};

    assign o_in_stall = ({1'b0, s1_emit} + {1'b0, r_o_valid} + {1'b0, r_sk_valid}) >
                        ({1'b0, deq} + 2'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid  <= 1'b0;
            r_sk_valid <= 1'b0;
        end else if (deq || !r_o_valid) begin
            r_o_valid  <= r_sk_valid | s1_emit;
            r_sk_valid <= r_sk_valid & s1_emit;
        end else if (s1_emit) begin
            r_sk_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (deq || !r_o_valid) begin
            if (r_sk_valid) begin
                r_o_req <= r_sk_req;
                if (s1_emit) begin
                    r_sk_req <= s1_req;
                end
            end else if (s1_emit) begin
                r_o_req <= s1_req;
            end
        end else if (s1_emit) begin
            r_sk_req <= s1_req;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_req   = r_o_req;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_valid |-> r_o_valid)
        else $error("skid holds a request while the output register is empty");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_emit |-> !r_sk_valid || deq)
        else $error("result arrives with no room in the output queue");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= w_p1)
        else $error("pending count beyond window lag");

    a_s1_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (live && !geo_wr) |=> r_s1_valid)
        else $error("accepted request did not reach the line buffer stage");

endmodule
